>>> rtl/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg
// Shared constants, types and helpers of the piezo hit detector.
// ----------------------------------------------------------------------------
package phd_pkg;

  // default widths of the sample path and the run counter
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int RUN_BITS_DEF    = 16;

  // fixed field widths
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int LIMIT_BITS    = 16;
  localparam int HIT_IDX_BITS  = 4;
  localparam int MOD_BITS      = 5;
  localparam int TICK_BITS     = 6;
  localparam int QUEUE_DEPTH   = 2;

  // longest window the tick counter allows
  localparam logic [TICK_BITS-1:0] PERIOD_LIMIT = 6'd62;

  // register reset values
  localparam logic [CFG_DATA_BITS-1:0] THRESHOLD_RST = 16'd100;
  localparam logic [LIMIT_BITS-1:0]    MIN_RUN_RST   = 16'd10;
  localparam logic [LIMIT_BITS-1:0]    MAX_RUN_RST   = 16'd100;
  localparam logic [MOD_BITS-1:0]      MODULUS_RST   = 5'd10;
  localparam logic [TICK_BITS-1:0]     PERIOD_RST    = 6'd10;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HIT_THRESHOLD = 3'd0,
    REG_MIN_RUN       = 3'd1,
    REG_MAX_RUN       = 3'd2,
    REG_HIT_MODULUS   = 3'd3,
    REG_REPORT_PERIOD = 3'd4
  } cfg_reg_t;

  // configuration as seen by the front end
  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] threshold;
    logic [LIMIT_BITS-1:0]    min_run;
    logic [LIMIT_BITS-1:0]    max_run;
    logic [MOD_BITS-1:0]      modulus;
    logic [TICK_BITS-1:0]     period;
  } cfg_t;

  // queue handshake between front and back
  typedef struct packed {
    logic push;
    logic full;
  } q_wr_ctl_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_ctl_t;

  // front end states
  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_FIX,
    F_HIT
  } front_state_t;

  // back end states
  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

  // width of one queue entry: level, hit, index, report flag, sum, count
  function automatic int entry_bits(int sample_bits);
    return sample_bits + 1 + HIT_IDX_BITS + 1 + (sample_bits + TICK_BITS) + TICK_BITS;
  endfunction

endpackage

>>> rtl/phd_if.sv
// ----------------------------------------------------------------------------
// phd_if
// Channel interfaces of the piezo hit detector: samples, results, config.
// ----------------------------------------------------------------------------
interface phd_in_if #(
  parameter int SAMPLE_BITS = phd_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface phd_out_if #(
  parameter int SAMPLE_BITS = phd_pkg::SAMPLE_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [SAMPLE_BITS-1:0]            filtered_level;
  logic                              hit;
  logic [phd_pkg::HIT_IDX_BITS-1:0]  hit_index;
  logic                              average_valid;
  logic [SAMPLE_BITS-1:0]            window_average;

  modport source (output valid, output filtered_level, output hit, output hit_index,
                  output average_valid, output window_average, input ready);
  modport sink (input valid, input filtered_level, input hit, input hit_index,
                input average_valid, input window_average, output ready);
endinterface

interface phd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [phd_pkg::CFG_IDX_BITS-1:0]   index;
  logic [phd_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/phd_queue.sv
// ----------------------------------------------------------------------------
// phd_queue
// Small flop-based queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module phd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = phd_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  phd_pkg::q_wr_ctl_t    wr_ctl,
  input  logic [WIDTH-1:0]      wr_data,
  output logic                  full,
  input  phd_pkg::q_rd_ctl_t    rd_ctl,
  output logic                  empty,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;
  logic                do_push;
  logic                do_pop;

  assign do_push = wr_ctl.push && !full;
  assign do_pop  = rd_ctl.pop && !empty;
  assign full    = (count_r == CNT_BITS'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_BITS'(DEPTH)))
    else $error("queue fill count beyond depth");

endmodule

>>> rtl/phd_front.sv
// ----------------------------------------------------------------------------
// phd_front
// Accepts samples, keeps the report window, smooths the level and tracks runs.
// ----------------------------------------------------------------------------
module phd_front #(
  parameter int SAMPLE_BITS = phd_pkg::SAMPLE_BITS_DEF,
  parameter int RUN_BITS    = phd_pkg::RUN_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  phd_in_if.sink                  in_ch,
  input  phd_pkg::cfg_t           cfg,
  output phd_pkg::q_wr_ctl_t      q_wr,
  input  logic                    q_full,
  output logic [phd_pkg::entry_bits(SAMPLE_BITS)-1:0] q_data
);

  localparam int TB       = phd_pkg::TICK_BITS;
  localparam int HB       = phd_pkg::HIT_IDX_BITS;
  localparam int MB       = phd_pkg::MOD_BITS;
  localparam int SUM_BITS = SAMPLE_BITS + TB;
  localparam int XW       = SAMPLE_BITS + 4;
  localparam int PW       = 2 * XW;
  localparam int RECIP    = (2 ** XW) / 10;
  localparam int CW       = (RUN_BITS > phd_pkg::LIMIT_BITS) ? RUN_BITS : phd_pkg::LIMIT_BITS;
  localparam logic [XW-1:0] RECIP_C = XW'(RECIP);
  localparam logic [XW-1:0] TEN_C   = XW'(10);

  phd_pkg::front_state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] smoothed_r;
  logic [RUN_BITS-1:0]    run_r;
  logic [HB-1:0]          hit_cnt_r;
  logic [TB-1:0]          tick_r;
  logic [SUM_BITS-1:0]    sum_r;
  logic [TB-1:0]          cnt_r;
  logic [XW-1:0]          x_r;
  logic [PW-1:0]          prod_r;
  logic                   rep_valid_r;
  logic [SUM_BITS-1:0]    rep_sum_r;
  logic [TB-1:0]          rep_cnt_r;

  logic                   accept;
  logic [TB-1:0]          period;
  logic [TB:0]            next_tick;
  logic                   report;
  logic [XW-1:0]          x_new;
  logic [XW-1:0]          q0;
  logic [XW-1:0]          rem;
  logic [XW-1:0]          q_fix;
  logic                   above;
  logic [CW-1:0]          run_ext;
  logic                   hit;
  logic [HB-1:0]          hit_index;
  logic [MB-1:0]          hit_next;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      phd_pkg::F_IDLE: if (in_ch.valid) state_nxt = phd_pkg::F_MUL;
      phd_pkg::F_MUL:  state_nxt = phd_pkg::F_FIX;
      phd_pkg::F_FIX:  state_nxt = phd_pkg::F_HIT;
      phd_pkg::F_HIT:  if (!q_full) state_nxt = phd_pkg::F_IDLE;
      default:         state_nxt = phd_pkg::F_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ch.ready = 1'b0;
    q_wr.push   = 1'b0;
    q_wr.full   = q_full;
    unique case (state_r)
      phd_pkg::F_IDLE: in_ch.ready = 1'b1;
      phd_pkg::F_HIT:  q_wr.push   = !q_full;
      default: ;
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;

  // window report decision, taken before this sample joins the window
  assign period    = (cfg.period > phd_pkg::PERIOD_LIMIT) ? phd_pkg::PERIOD_LIMIT : cfg.period;
  assign next_tick = {1'b0, tick_r} + 1'b1;
  assign report    = next_tick > {1'b0, period};

  // 9 * level + sample
  assign x_new = XW'({smoothed_r, 3'b000}) + XW'(smoothed_r) + XW'(in_ch.sample);

  // divide by ten: reciprocal estimate, then one correction step
  assign q0    = prod_r[PW-1:XW];
  assign rem   = x_r - ((q0 << 3) + (q0 << 1));
  assign q_fix = (rem >= TEN_C) ? q0 + 1'b1 : q0;

  // run tracking and hit qualification
  assign above     = smoothed_r > cfg.threshold[SAMPLE_BITS-1:0];
  assign run_ext   = CW'(run_r);
  assign hit       = !above && (run_ext > CW'(cfg.min_run)) && (run_ext < CW'(cfg.max_run));
  assign hit_index = hit ? hit_cnt_r : '0;
  assign hit_next  = {1'b0, hit_cnt_r} + 1'b1;

  assign q_data = {smoothed_r, hit, hit_index, rep_valid_r, rep_sum_r, rep_cnt_r};

  // control and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= phd_pkg::F_IDLE;
      smoothed_r <= '0;
      run_r      <= '0;
      hit_cnt_r  <= '0;
      tick_r     <= '0;
      sum_r      <= '0;
      cnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (report) begin
          tick_r <= '0;
          sum_r  <= SUM_BITS'(in_ch.sample);
          cnt_r  <= TB'(1);
        end else begin
          tick_r <= next_tick[TB-1:0];
          sum_r  <= sum_r + SUM_BITS'(in_ch.sample);
          cnt_r  <= cnt_r + 1'b1;
        end
      end
      if (state_r == phd_pkg::F_FIX) begin
        smoothed_r <= q_fix[SAMPLE_BITS-1:0];
      end
      if (q_wr.push) begin
        if (above) begin
          if (run_r != '1) begin
            run_r <= run_r + 1'b1;
          end
        end else begin
          run_r <= '0;
          if (hit) begin
            hit_cnt_r <= (hit_next >= cfg.modulus) ? '0 : hit_next[HB-1:0];
          end
        end
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r         <= x_new;
      rep_valid_r <= report;
      rep_sum_r   <= sum_r;
      rep_cnt_r   <= cnt_r;
    end
    if (state_r == phd_pkg::F_MUL) begin
      prod_r <= x_r * RECIP_C;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == phd_pkg::F_FIX) |-> (rem < 2 * TEN_C))
    else $error("reciprocal estimate off by more than one");

  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == phd_pkg::F_MUL) && !in_ch.ready)
    else $error("front took an item while busy");

endmodule

>>> rtl/phd_back.sv
// ----------------------------------------------------------------------------
// phd_back
// Pops queued items, divides the window sum by its count and drives results.
// ----------------------------------------------------------------------------
module phd_back #(
  parameter int SAMPLE_BITS = phd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  output phd_pkg::q_rd_ctl_t      q_rd,
  input  logic                    q_empty,
  input  logic [phd_pkg::entry_bits(SAMPLE_BITS)-1:0] q_data,
  phd_out_if.source               out_ch
);

  localparam int TB        = phd_pkg::TICK_BITS;
  localparam int HB        = phd_pkg::HIT_IDX_BITS;
  localparam int SUM_BITS  = SAMPLE_BITS + TB;
  localparam int STEP_BITS = $clog2(SUM_BITS);

  phd_pkg::back_state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] filt_r;
  logic                   hit_r;
  logic [HB-1:0]          idx_r;
  logic                   avv_r;
  logic [SUM_BITS-1:0]    quo_r;
  logic [TB-1:0]          rem_r;
  logic [TB-1:0]          div_r;
  logic [STEP_BITS-1:0]   step_r;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_filt_r;
  logic                   out_hit_r;
  logic [HB-1:0]          out_idx_r;
  logic                   out_avv_r;
  logic [SAMPLE_BITS-1:0] out_avg_r;

  logic [SAMPLE_BITS-1:0] e_filt;
  logic                   e_hit;
  logic [HB-1:0]          e_idx;
  logic                   e_avv;
  logic [SUM_BITS-1:0]    e_sum;
  logic [TB-1:0]          e_cnt;
  logic                   e_divide;
  logic [TB:0]            rem_sh;
  logic                   ge;
  logic [TB:0]            rem_sub;
  logic                   last_step;
  logic                   load_out;

  // queue entry fields
  assign {e_filt, e_hit, e_idx, e_avv, e_sum, e_cnt} = q_data;
  assign e_divide = e_avv && (e_cnt != '0);

  // one restoring division step
  assign rem_sh    = {rem_r, quo_r[SUM_BITS-1]};
  assign ge        = rem_sh >= {1'b0, div_r};
  assign rem_sub   = rem_sh - {1'b0, div_r};
  assign last_step = (step_r == STEP_BITS'(SUM_BITS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      phd_pkg::B_IDLE: begin
        if (!q_empty) state_nxt = e_divide ? phd_pkg::B_DIV : phd_pkg::B_DONE;
      end
      phd_pkg::B_DIV:  if (last_step) state_nxt = phd_pkg::B_DONE;
      phd_pkg::B_DONE: if (!out_valid_r || out_ch.ready) state_nxt = phd_pkg::B_IDLE;
      default:         state_nxt = phd_pkg::B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_rd.pop   = 1'b0;
    q_rd.empty = q_empty;
    load_out   = 1'b0;
    unique case (state_r)
      phd_pkg::B_IDLE: q_rd.pop = !q_empty;
      phd_pkg::B_DONE: load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= phd_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item fields and divider
  always_ff @(posedge clk) begin
    if (q_rd.pop) begin
      filt_r <= e_filt;
      hit_r  <= e_hit;
      idx_r  <= e_idx;
      avv_r  <= e_avv;
      quo_r  <= e_divide ? e_sum : '0;
      rem_r  <= '0;
      div_r  <= e_cnt;
      step_r <= '0;
    end else if (state_r == phd_pkg::B_DIV) begin
      rem_r  <= ge ? rem_sub[TB-1:0] : rem_sh[TB-1:0];
      quo_r  <= {quo_r[SUM_BITS-2:0], ge};
      step_r <= step_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_filt_r <= filt_r;
      out_hit_r  <= hit_r;
      out_idx_r  <= idx_r;
      out_avv_r  <= avv_r;
      out_avg_r  <= quo_r[SAMPLE_BITS-1:0];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_level = out_filt_r;
  assign out_ch.hit            = out_hit_r;
  assign out_ch.hit_index      = out_idx_r;
  assign out_ch.average_valid  = out_avv_r;
  assign out_ch.window_average = out_avg_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == phd_pkg::B_DIV) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_avv_r) |-> (out_avg_r == '0))
    else $error("average shown without a report");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_idx_r == '0))
    else $error("hit index shown without a hit");

endmodule

>>> rtl/piezo_hit_detector_with_window_average_top.sv
// ----------------------------------------------------------------------------
// piezo_hit_detector_with_window_average_top
// Smoothed piezo level, run-length hit detection and windowed sample mean.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   sample
//   out_ch   out  valid/ready   filtered_level, hit, hit_index,
//                               average_valid, window_average
//   cfg_ch   in   valid/ready   index, data (ready always high)
//
// the front end takes one item at a time through accept, reciprocal multiply,
// divide-by-ten correction, run update and queue write, the last waiting on a full queue
// the back end pops an item, runs the one-bit-per-cycle window divider when an average
// is reported with a nonzero count, and waits on out_ch ready before loading the result
// a 2-entry queue and the result register let either side stall alone
// synchronous active-low reset; no clearing pass
// ----------------------------------------------------------------------------
module piezo_hit_detector_with_window_average_top #(
  parameter int SAMPLE_BITS = phd_pkg::SAMPLE_BITS_DEF,
  parameter int RUN_BITS    = phd_pkg::RUN_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  phd_in_if.sink       in_ch,
  phd_out_if.source    out_ch,
  phd_cfg_if.sink      cfg_ch
);

  localparam int ENTRY_BITS = phd_pkg::entry_bits(SAMPLE_BITS);

  phd_pkg::cfg_t      cfg_r;
  phd_pkg::q_wr_ctl_t q_wr;
  phd_pkg::q_rd_ctl_t q_rd;
  logic               q_full;
  logic               q_empty;
  logic [ENTRY_BITS-1:0] q_wdata;
  logic [ENTRY_BITS-1:0] q_rdata;

  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= phd_pkg::THRESHOLD_RST;
      cfg_r.min_run   <= phd_pkg::MIN_RUN_RST;
      cfg_r.max_run   <= phd_pkg::MAX_RUN_RST;
      cfg_r.modulus   <= phd_pkg::MODULUS_RST;
      cfg_r.period    <= phd_pkg::PERIOD_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (phd_pkg::cfg_reg_t'(cfg_ch.index))
        phd_pkg::REG_HIT_THRESHOLD:
          cfg_r.threshold <= phd_pkg::CFG_DATA_BITS'(cfg_ch.data[SAMPLE_BITS-1:0]);
        phd_pkg::REG_MIN_RUN:
          cfg_r.min_run <= cfg_ch.data[phd_pkg::LIMIT_BITS-1:0];
        phd_pkg::REG_MAX_RUN:
          cfg_r.max_run <= cfg_ch.data[phd_pkg::LIMIT_BITS-1:0];
        phd_pkg::REG_HIT_MODULUS:
          cfg_r.modulus <= cfg_ch.data[phd_pkg::MOD_BITS-1:0];
        phd_pkg::REG_REPORT_PERIOD:
          cfg_r.period <= cfg_ch.data[phd_pkg::TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sample intake, filter and run tracking
  phd_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .RUN_BITS    (RUN_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_data (q_wdata)
  );

  // decoupling queue
  phd_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (phd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_ctl  (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_ctl  (q_rd),
    .empty   (q_empty),
    .rd_data (q_rdata)
  );

  // window divider and result register
  phd_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_rd    (q_rd),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .out_ch  (out_ch)
  );

endmodule
